>>> src/ipd_pkg.sv
`timescale 1ns / 1ps

package ipd_pkg;

  // fixed field widths
  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int OUT_DATA_W = 2 * DATA_W;

  // defaults for the top-level parameters
  localparam int FRAME_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  // register map
  localparam cfg_addr_t REG_START_PERIOD = 2'd0;
  localparam cfg_addr_t REG_ONE_PERIOD   = 2'd1;
  localparam cfg_addr_t REG_ZERO_PERIOD  = 2'd2;
  localparam cfg_addr_t REG_WINDOW_TOL   = 2'd3;

  // request codes carried in the input tuser
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_ONE   = 2'd1,
    CLS_START = 2'd2,
    CLS_BAD   = 2'd3
  } sym_cls_t;

  // one classified request travelling from front to back
  typedef struct packed {
    logic     is_read;
    sym_cls_t cls;
  } qentry_t;

endpackage

>>> src/ipd_front.sv
`timescale 1ns / 1ps

module ipd_front import ipd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  cfg_addr_t         cfg_addr,
  input  logic [DATA_W-1:0] cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              in_tuser,
  input  logic              q_full,
  output logic              q_push,
  output qentry_t           q_entry
);

  logic [DATA_W-1:0] start_period_r;
  logic [DATA_W-1:0] one_period_r;
  logic [DATA_W-1:0] zero_period_r;
  logic [DATA_W-1:0] window_tol_r;

  // exclusive window, both bounds wrap modulo 2^32
  function automatic logic in_window(input logic [DATA_W-1:0] t,
                                     input logic [DATA_W-1:0] nominal,
                                     input logic [DATA_W-1:0] tol);
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    lo = nominal - tol;
    hi = nominal + tol;
    return (t > lo) && (t < hi);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_period_r <= '0;
      one_period_r   <= '0;
      zero_period_r  <= '0;
      window_tol_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_PERIOD: start_period_r <= cfg_wdata;
        REG_ONE_PERIOD:   one_period_r   <= cfg_wdata;
        REG_ZERO_PERIOD:  zero_period_r  <= cfg_wdata;
        REG_WINDOW_TOL:   window_tol_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // priority zero, one, start
  always_comb begin
    q_entry.is_read = (in_tuser == FUNC_READ);
    if (q_entry.is_read)
      q_entry.cls = CLS_BAD;
    else if (in_window(in_tdata, zero_period_r, window_tol_r))
      q_entry.cls = CLS_ZERO;
    else if (in_window(in_tdata, one_period_r, window_tol_r))
      q_entry.cls = CLS_ONE;
    else if (in_window(in_tdata, start_period_r, window_tol_r))
      q_entry.cls = CLS_START;
    else
      q_entry.cls = CLS_BAD;
  end

endmodule

>>> src/ipd_queue.sv
`timescale 1ns / 1ps

module ipd_queue import ipd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t wdata,
  output logic    full,
  output logic    valid,
  input  logic    pop,
  output qentry_t rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qentry_t              entry_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CNT_W-1:0]     count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1))
      return '0;
    return p + 1'b1;
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign valid = (count_r != '0);
  assign rdata = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push)
      entry_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)
        count_r <= count_r + 1'b1;
      else if (pop && !push)
        count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CNT_W'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue read while empty");

endmodule

>>> src/ipd_back.sv
`timescale 1ns / 1ps

module ipd_back import ipd_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  qentry_t               q_entry,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  localparam int CNT_W = $clog2(FRAME_BITS + 1);

  logic [FRAME_BITS-1:0] shift_r,   shift_nxt;
  logic [CNT_W-1:0]      count_r,   count_nxt;
  logic [DATA_W-1:0]     held_r,    held_nxt;
  logic [DATA_W-1:0]     tally_r,   tally_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0]     out_cmd_r, out_cmd_nxt;
  logic [DATA_W-1:0]     out_err_r, out_err_nxt;
  sym_cls_t              out_cls_r, out_cls_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  idle;
  logic [FRAME_BITS-1:0] shift_step;

  assign q_pop      = q_valid && (!out_tvalid_r || out_tready);
  assign idle       = (count_r >= CNT_W'(FRAME_BITS));
  // msb first: new bit enters at the bottom
  assign shift_step = (shift_r << 1) | FRAME_BITS'(q_entry.cls[0]);

  always_comb begin
    shift_nxt      = shift_r;
    count_nxt      = count_r;
    held_nxt       = held_r;
    tally_nxt      = tally_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_cmd_nxt    = out_cmd_r;
    out_err_nxt    = out_err_r;
    out_cls_nxt    = out_cls_r;
    out_last_nxt   = out_last_r;
    if (q_pop) begin
      out_tvalid_nxt = 1'b1;
      out_last_nxt   = 1'b0;
      if (q_entry.is_read) begin
        out_cmd_nxt = held_r;
        held_nxt    = '0;
        out_cls_nxt = CLS_BAD;
      end else begin
        out_cmd_nxt = '0;
        out_cls_nxt = q_entry.cls;
        case (q_entry.cls) inside
          CLS_ZERO, CLS_ONE: begin
            if (!idle) begin
              shift_nxt = shift_step;
              count_nxt = count_r + 1'b1;
              if (count_r == CNT_W'(FRAME_BITS - 1)) begin
                held_nxt     = DATA_W'(shift_step);
                out_last_nxt = 1'b1;
              end
            end
          end
          CLS_START: begin
            shift_nxt = '0;
            count_nxt = '0;
          end
          default: begin
            // timing error only counts inside a frame
            if (!idle) begin
              count_nxt = CNT_W'(FRAME_BITS);
              tally_nxt = tally_r + 1'b1;
            end
          end
        endcase
      end
      out_err_nxt = tally_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r      <= '0;
      count_r      <= CNT_W'(FRAME_BITS);
      held_r       <= '0;
      tally_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      shift_r      <= shift_nxt;
      count_r      <= count_nxt;
      held_r       <= held_nxt;
      tally_r      <= tally_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_cmd_r  <= out_cmd_nxt;
    out_err_r  <= out_err_nxt;
    out_cls_r  <= out_cls_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_err_r, out_cmd_r};
  assign out_tuser  = out_cls_r;
  assign out_tlast  = out_last_r;

  a_done_is_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_last_r) |-> (out_cls_r == CLS_ZERO || out_cls_r == CLS_ONE))
    else $error("frame completion on a non-bit symbol");

  a_cmd_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_cmd_r != '0) |-> (out_cls_r == CLS_BAD && !out_last_r))
    else $error("command returned outside a read");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_entry.is_read && q_entry.cls == CLS_START) |=> (count_r == '0))
    else $error("start symbol did not restart the frame");

endmodule

>>> src/ir_pulse_distance_decoder_top.sv
`timescale 1ns / 1ps
// an input transfer is written into the queue, then moves to the output register behind out_tvalid
// throughput: one transfer per cycle on each side unless the queue is full or out_tready is low;
//   the window compare in the front end is combinational and the back end updates its frame on each pop
// reset: synchronous, active low; window registers, shift word, held command and error
//   count clear to zero, bit count goes to idle, queue and output register empty

module ir_pulse_distance_decoder_top import ipd_pkg::*; #(
  parameter int FRAME_BITS  = FRAME_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes, no read-back
  input  logic                  cfg_we,
  input  cfg_addr_t             cfg_addr,
  input  logic [DATA_W-1:0]     cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // interval
  input  logic                  in_tuser,   // func
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // command, errors_seen
  output logic [1:0]            out_tuser,  // symbol_class
  output logic                  out_tlast   // frame_done
);

  // front to queue
  logic    q_push;
  logic    q_full;
  qentry_t q_wentry;
  // queue to back
  logic    q_valid;
  logic    q_pop;
  qentry_t q_rentry;

  // front: holds the windows and classifies every transfer as it is accepted
  ipd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wentry)
  );

  // short queue so the input side keeps moving while a result waits
  ipd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wentry),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_rentry)
  );

  // back: frame assembly, command latch, error count and output register
  ipd_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_rentry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> dv/ir_pulse_distance_decoder_top_test.sv
`timescale 1ns / 1ps

module ir_pulse_distance_decoder_top_test;
  import ipd_pkg::*;

  localparam int FRAME_LEN = FRAME_BITS_DEF;
  localparam int IDLE_BITS = 32;          // any count >= FRAME_LEN means idle
  localparam int GAP_MAX   = 13;

  // one pending input transfer: request code, interval, pause after it, hold-off flag
  typedef struct {
    logic        func;
    logic [31:0] ticks;
    int          gap;
    bit          drain;     // wait for every outstanding result before sending
  } ir_event_t;

  // one predicted result transfer
  typedef struct {
    logic [31:0] command;
    sym_cls_t    cls;
    logic        done;
    logic [31:0] errors;
  } sym_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_addr_t             cfg_addr = REG_START_PERIOD;
  logic [DATA_W-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata = '0;    // interval
  logic                  in_tuser = 1'b0;  // func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // command, errors_seen
  logic [1:0]            out_tuser;        // symbol_class
  logic                  out_tlast;        // frame_done

  ir_pulse_distance_decoder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 12 ns period
  initial begin
    forever #6 clk = ~clk;
  end

  // generous fixed limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("ir_pulse_distance_decoder_top_test: done, errors");
    $finish;
  end

  // pending stimulus and outstanding predictions
  ir_event_t   ir_events[$];
  sym_result_t predicted_symbols[$];

  // decoder mirror: window registers as written on the bus
  logic [31:0] win_start = '0;
  logic [31:0] win_one   = '0;
  logic [31:0] win_zero  = '0;
  logic [31:0] win_tol   = '0;
  // decoder mirror: frame state
  logic [31:0] frame_shift = '0;
  int          frame_bits  = IDLE_BITS;
  logic [31:0] latched_cmd = '0;
  logic [31:0] err_count   = '0;

  // stimulus side copy of the current window setting
  logic [31:0] set_start, set_one, set_zero, set_tol;

  int in_offered = 0;       // transfers put on the input bus
  int in_taken   = 0;       // input transfers accepted
  int out_taken  = 0;       // result transfers accepted
  int out_counted = 0;
  int send_gap   = 0;
  int recv_stall = 0;
  int recv_stall_max = GAP_MAX;
  int fails      = 0;
  int frames_done = 0;
  int reads_seen  = 0;
  int settings    = 0;
  int phase_items = 0;

  // exclusive window test, both bounds taken modulo 2^32
  function automatic bit fits(logic [31:0] ticks, logic [31:0] nominal);
    logic [31:0] lo, hi;
    lo = nominal - win_tol;
    hi = nominal + win_tol;
    return (ticks > lo) && (ticks < hi);
  endfunction

  // advance the decoder mirror by one input transfer and return what it should produce
  function automatic sym_result_t decode_event(logic func, logic [31:0] ticks);
    sym_result_t r;
    r.command = '0;
    r.done    = 1'b0;
    if (func == FUNC_READ) begin
      // read and clear, no symbol, frame state untouched
      r.command   = latched_cmd;
      latched_cmd = '0;
      r.cls       = CLS_BAD;
      r.errors    = err_count;
      return r;
    end
    // priority: zero, then one, then start
    if (fits(ticks, win_zero))
      r.cls = CLS_ZERO;
    else if (fits(ticks, win_one))
      r.cls = CLS_ONE;
    else if (fits(ticks, win_start))
      r.cls = CLS_START;
    else
      r.cls = CLS_BAD;
    case (r.cls)
      CLS_ZERO, CLS_ONE: begin
        // bits while idle are dropped
        if (frame_bits < FRAME_LEN) begin
          frame_shift = {frame_shift[30:0], r.cls == CLS_ONE};
          frame_bits++;
          if (frame_bits == FRAME_LEN) begin
            latched_cmd = frame_shift;   // overwrites anything unread
            r.done      = 1'b1;
          end
        end
      end
      CLS_START: begin
        // also restarts a frame in progress, no error
        frame_bits  = 0;
        frame_shift = '0;
      end
      default: begin
        // bad timing only counts inside a frame
        if (frame_bits < FRAME_LEN) begin
          frame_bits = IDLE_BITS;
          err_count  = err_count + 1;
        end
      end
    endcase
    r.errors = err_count;
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      fails++;
    end
  endtask

  // sampling at the rising edge: register writes, input transfers, result transfers
  always @(posedge clk) begin
    sym_result_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_START_PERIOD: win_start = cfg_wdata;
          REG_ONE_PERIOD:   win_one   = cfg_wdata;
          REG_ZERO_PERIOD:  win_zero  = cfg_wdata;
          REG_WINDOW_TOL:   win_tol   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        predicted_symbols.push_back(decode_event(in_tuser, in_tdata));
        in_taken++;
      end
      if (out_tvalid && out_tready) begin
        out_taken++;
        if (predicted_symbols.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %h/%h/%b",
                   $time, out_tdata, out_tuser, out_tlast);
          fails++;
        end else begin
          want = predicted_symbols.pop_front();
          check_field("command", want.command, out_tdata[31:0]);
          check_field("symbol_class", 32'(want.cls), 32'(out_tuser));
          check_field("frame_done", 32'(want.done), 32'(out_tlast));
          check_field("errors_seen", want.errors, out_tdata[63:32]);
          if (want.done)
            frames_done++;
          if (want.command != '0)
            reads_seen++;
        end
      end
    end
  end

  // sender: drives at the falling edge, holds until the transfer is taken
  always @(negedge clk) begin
    ir_event_t ev;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_taken == in_offered) begin
      // bus is free, either pause or present the next item
      if (send_gap != 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (ir_events.size() != 0 &&
                   !(ir_events[0].drain && predicted_symbols.size() != 0)) begin
        ev = ir_events.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= ev.func;
        in_tdata  <= ev.ticks;
        in_offered++;
        send_gap = ev.gap;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall drawn after every result transfer
  always @(negedge clk) begin
    if (out_taken != out_counted) begin
      out_counted = out_taken;
      recv_stall  = $urandom_range(0, recv_stall_max);
    end
    if (recv_stall != 0) begin
      recv_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic add(logic func, logic [31:0] ticks, bit quiet, bit drain);
    ir_event_t ev;
    ev.func  = func;
    ev.ticks = ticks;
    ev.gap   = quiet ? 0 : $urandom_range(0, GAP_MAX);
    ev.drain = drain;
    ir_events.push_back(ev);
    phase_items++;
  endtask

  // an interval aimed at one window, mostly inside, sometimes on its edge or just inside it
  function automatic logic [31:0] aim(logic [31:0] nominal);
    logic [31:0] span;
    span = (set_tol == 0) ? 32'd0 : ((set_tol - 1 > 1000000) ? 32'd1000000 : set_tol - 1);
    case ($urandom_range(0, 19))
      0:       return nominal - set_tol;
      1:       return nominal + set_tol;
      2:       return nominal - span;
      3:       return nominal + span;
      default: return nominal - span + $urandom_range(0, 2 * span);
    endcase
  endfunction

  // write all four window registers, only while the decoder is idle
  task automatic set_windows(input logic [31:0] s, o, z, t);
    set_start = s;
    set_one   = o;
    set_zero  = z;
    set_tol   = t;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_START_PERIOD;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_addr  <= REG_ONE_PERIOD;
    cfg_wdata <= o;
    @(negedge clk);
    cfg_addr  <= REG_ZERO_PERIOD;
    cfg_wdata <= z;
    @(negedge clk);
    cfg_addr  <= REG_WINDOW_TOL;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // wait until every queued item is sent and every result is back, then let the pipe settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((ir_events.size() != 0 || in_taken != in_offered ||
            predicted_symbols.size() != 0) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // random traffic: mostly full frames with random payload, plus broken frames, noise and reads
  task automatic run_random(int count);
    int          pick, nbits;
    bit          quiet, first;
    logic [31:0] word;
    phase_items = 0;
    first = 1'b1;
    while (phase_items < count) begin
      pick  = $urandom_range(0, 99);
      quiet = ($urandom_range(0, 3) == 0);   // stretches with no sender gaps
      if (pick < 60) begin
        // well-formed frame, first one of a phase waits for the pipe to empty
        word = $urandom;
        add(FUNC_EDGE, aim(set_start), quiet, first || ($urandom_range(0, 49) == 0));
        first = 1'b0;
        for (int b = FRAME_LEN - 1; b >= 0; b--)
          add(FUNC_EDGE, word[b] ? aim(set_one) : aim(set_zero), quiet, 1'b0);
        if ($urandom_range(0, 9) < 7)
          add(FUNC_READ, $urandom, quiet, 1'b0);
      end else if (pick < 75) begin
        // frame cut short by bad timing, a restart or an interleaved read
        add(FUNC_EDGE, aim(set_start), quiet, 1'b0);
        nbits = $urandom_range(0, FRAME_LEN - 1);
        for (int b = 0; b < nbits; b++)
          add(FUNC_EDGE, $urandom_range(0, 1) ? aim(set_one) : aim(set_zero), quiet, 1'b0);
        case ($urandom_range(0, 2))
          0:       add(FUNC_EDGE, $urandom, quiet, 1'b0);
          1:       add(FUNC_EDGE, aim(set_start), quiet, 1'b0);
          default: add(FUNC_READ, $urandom, quiet, 1'b0);
        endcase
      end else if (pick < 90) begin
        // noise: full-range intervals, the extremes and stray intervals aimed at the one or zero window
        case ($urandom_range(0, 3))
          0:       add(FUNC_EDGE, 32'h0000_0000, quiet, 1'b0);
          1:       add(FUNC_EDGE, 32'hFFFF_FFFF, quiet, 1'b0);
          2:       add(FUNC_EDGE, aim($urandom_range(0, 1) ? set_one : set_zero), quiet, 1'b0);
          default: add(FUNC_EDGE, $urandom, quiet, 1'b0);
        endcase
      end else begin
        add(FUNC_READ, $urandom, quiet, 1'b0);
      end
    end
  endtask

  initial begin
    // reset held from time zero, then released once
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register defaults after reset: every window empty, so everything is unrecognised
    set_start = '0;
    set_one   = '0;
    set_zero  = '0;
    set_tol   = '0;
    add(FUNC_READ, 32'h0000_0000, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'h0000_0000, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'h0000_0001, 1'b0, 1'b0);
    wait_idle();

    // typical timing, directed special cases
    set_windows(32'd13500, 32'd2250, 32'd1125, 32'd300);
    // bits and bad intervals while idle are ignored
    add(FUNC_EDGE, 32'd1125, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd2250, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd5000, 1'b0, 1'b0);
    // bad interval inside a frame bumps the error count
    add(FUNC_EDGE, 32'd13500, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd2250, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd1125, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd4000, 1'b0, 1'b0);
    // restart mid-frame, read of an incomplete frame gives zero
    add(FUNC_EDGE, 32'd13500, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd2250, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd13300, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd1000, 1'b0, 1'b0);
    add(FUNC_READ, 32'hFFFF_FFFF, 1'b0, 1'b0);
    // window edges are exclusive
    add(FUNC_EDGE, 32'd825, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd13500, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd1425, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd13201, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd826, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd2549, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd1951, 1'b0, 1'b0);
    add(FUNC_EDGE, 32'd13799, 1'b0, 1'b0);
    add(FUNC_READ, 32'h0000_0000, 1'b0, 1'b0);
    wait_idle();

    // random phases, one window setting each
    recv_stall_max = GAP_MAX;
    run_random(450);
    wait_idle();

    // overlapping zero and one windows, zero wins; receiver never stalls
    set_windows(32'd9999, 32'd1100, 32'd1000, 32'd200);
    recv_stall_max = 0;
    run_random(350);
    wait_idle();

    // single-tick windows, start near the top of the range
    set_windows(32'hFFFF_FFFE, 32'd2, 32'd1, 32'd1);
    recv_stall_max = GAP_MAX;
    run_random(300);
    wait_idle();

    // one window wraps and accepts nothing
    set_windows(32'h0000_1000, 32'hFFFF_FF00, 32'h8000_0000, 32'h0000_0200);
    recv_stall_max = 3;
    run_random(200);
    wait_idle();

    // everything at the maximum: every window takes 1 to 0xFFFFFFFD, so zero wins
    set_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    recv_stall_max = GAP_MAX;
    run_random(150);
    wait_idle();

    if (predicted_symbols.size() != 0) begin
      $display("%0t: %0d results still outstanding, expected none", $time,
               predicted_symbols.size());
      fails++;
    end

    $display("%0d result transfers checked over %0d window settings", out_taken, settings);
    $display("%0d frames completed, %0d non-zero commands read back, error count at %0d",
             frames_done, reads_seen, err_count);
    if (fails == 0)
      $display("ir_pulse_distance_decoder_top_test: done, clean");
    else
      $display("ir_pulse_distance_decoder_top_test: done, errors");
    $finish;
  end

endmodule
